@@ design/crc_checked_temp_humidity_frame_decoder_defines.svh @@
// Assertion macros for the sensor frame decoder.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef CRC_CHECKED_TEMP_HUMIDITY_FRAME_DECODER_DEFINES_SVH
`define CRC_CHECKED_TEMP_HUMIDITY_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CTHFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cthfd: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CTHFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cthfd: next-cycle check failed");

`endif

@@ design/cthfd_pkg.sv @@
// Shared types, constants and the CRC-8 byte update for the sensor frame decoder.
// No dependencies.
`default_nettype none

package cthfd_pkg;

  localparam logic [7:0]  CRC_POLY    = 8'h31;  // x^8+x^5+x^4+1, top bit implied
  localparam logic [7:0]  CRC_INIT    = 8'hFF;
  localparam logic [2:0]  FRAME_BYTES = 3'd6;
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [14:0] HUM_SPAN    = 15'd10000;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [13:0] HUM_MAX     = 14'd10000;

  // Byte positions within a frame.
  localparam logic [2:0] POS_TEMP_HI  = 3'd0;
  localparam logic [2:0] POS_TEMP_LO  = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_HI   = 3'd3;
  localparam logic [2:0] POS_HUM_LO   = 3'd4;
  localparam logic [2:0] POS_HUM_CRC  = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_beat_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic               temperature_crc_ok;
    logic               humidity_crc_ok;
  } out_beat_t;

  typedef struct packed {
    logic load;
    logic temp_sel;
  } scale_ctl_t;

  // One byte through the CRC-8 register, MSB first.
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/cthfd_scaler.sv @@
// Scales a 16-bit raw sensor word by a span and divides by full scale (65535).
// Depends on cthfd_pkg for the span constants and the control struct.
`default_nettype none

module cthfd_scaler
  import cthfd_pkg::*;
(
  input  wire logic        clk,
  input  wire scale_ctl_t  ctl,
  input  wire logic [15:0] word,
  output logic      [14:0] quotient
);

  logic [30:0] product;
  logic [14:0] span;
  logic [31:0] sum;

  assign span = ctl.temp_sel ? TEMP_SPAN : HUM_SPAN;

  // The product is registered when the low data byte arrives; the divide
  // happens when the CRC byte follows.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      product <= {15'd0, word} * {16'd0, span};
    end
  end

  // x / 65535 == (x + (x >> 16) + 1) >> 16 for every quotient below 65536.
  assign sum      = {1'b0, product} + {17'd0, product[30:16]} + 32'd1;
  assign quotient = sum[30:16];

endmodule

`default_nettype wire

@@ design/crc_checked_temp_humidity_frame_decoder.sv @@
// Top level of the CRC-checked temperature and humidity frame decoder.
// Depends on cthfd_pkg, cthfd_scaler and the assertion macro header.
//
// Usage: bytes of a sensor read frame enter on the in channel, one per beat,
// in the order temperature high, low, CRC, humidity high, low, CRC. A beat
// with frame_start set is taken as the first byte and drops any partial frame.
// Each word whose CRC-8 (poly 0x31, init 0xFF) matches is converted and held;
// a failing word leaves the previous held value.
// Throughput is one byte per cycle while in_stall is low. The result beat
// appears on the out channel in the cycle after the sixth byte is accepted and
// carries both held values and both CRC flags of the frame. The divide by full
// scale is a reciprocal add on the product registered at the low data byte.
// While a result waits under out_stall, bytes keep flowing until the next
// byte would complete a frame; only then is in_stall raised.
// Reset (synchronous) clears the byte position, the held values and the
// output valid; no clearing pass is needed.
`default_nettype none
`include "crc_checked_temp_humidity_frame_decoder_defines.svh"

module crc_checked_temp_humidity_frame_decoder
  import cthfd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_beat_t in_beat,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_beat_t     out_beat
);

  logic [2:0]         byte_position;
  logic [7:0]         crc_accumulator;
  logic [7:0]         raw_word_hi;
  logic signed [14:0] temperature_held;
  logic [13:0]        humidity_held;
  logic               temperature_check_flag;

  logic               in_fire;
  logic [2:0]         pos;
  logic [2:0]         pos_next;
  logic               crc_match;
  logic [14:0]        quotient;
  logic [15:0]        temp_wide;
  logic signed [14:0] temp_conv;
  logic [13:0]        hum_conv;
  scale_ctl_t         scale_ctl;

  // A byte has to wait for the result slot only while the next position is the closing CRC.
  assign in_stall = out_valid && out_stall && (byte_position == POS_HUM_CRC);
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    if (in_beat.frame_start || (byte_position >= FRAME_BYTES)) begin
      pos = POS_TEMP_HI;
    end else begin
      pos = byte_position;
    end
    pos_next = (pos == POS_HUM_CRC) ? POS_TEMP_HI : pos + 3'd1;
  end

  assign crc_match = (crc_accumulator == in_beat.data_byte);

  assign scale_ctl = '{
    load:     in_fire && ((pos == POS_TEMP_LO) || (pos == POS_HUM_LO)),
    temp_sel: (pos == POS_TEMP_LO)
  };

  cthfd_scaler u_scaler (
    .clk      (clk),
    .ctl      (scale_ctl),
    .word     ({raw_word_hi, in_beat.data_byte}),
    .quotient (quotient)
  );

  assign temp_wide = {1'b0, quotient} - TEMP_OFFSET;
  assign temp_conv = signed'(temp_wide[14:0]);
  assign hum_conv  = quotient[13:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position          <= POS_TEMP_HI;
      crc_accumulator        <= CRC_INIT;
      raw_word_hi            <= 8'd0;
      temperature_held       <= 15'sd0;
      humidity_held          <= 14'd0;
      temperature_check_flag <= 1'b0;
      out_valid              <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        byte_position <= pos_next;
        case (pos)
          POS_TEMP_HI, POS_HUM_HI: begin
            crc_accumulator <= crc8_update(CRC_INIT, in_beat.data_byte);
            raw_word_hi     <= in_beat.data_byte;
          end
          POS_TEMP_LO, POS_HUM_LO: begin
            crc_accumulator <= crc8_update(crc_accumulator, in_beat.data_byte);
          end
          POS_TEMP_CRC: begin
            if (crc_match) begin
              temperature_held <= temp_conv;
            end
            temperature_check_flag <= crc_match;
            crc_accumulator        <= CRC_INIT;
          end
          POS_HUM_CRC: begin
            if (crc_match) begin
              humidity_held <= hum_conv;
            end
            crc_accumulator <= CRC_INIT;
            out_valid       <= 1'b1;
          end
          default: begin
            crc_accumulator <= CRC_INIT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (pos == POS_HUM_CRC)) begin
      out_beat.temperature_centi  <= temperature_held;
      out_beat.humidity_centi     <= crc_match ? hum_conv : humidity_held;
      out_beat.temperature_crc_ok <= temperature_check_flag;
      out_beat.humidity_crc_ok    <= crc_match;
    end
  end

  `CTHFD_ASSERT_NOW(a_pos_in_frame, 1'b1, byte_position < FRAME_BYTES)
  `CTHFD_ASSERT_NOW(a_stall_needs_full_slot, in_stall, out_valid && out_stall)
  `CTHFD_ASSERT_NEXT(a_frame_end_gives_result, in_fire && (pos == POS_HUM_CRC), out_valid)
  `CTHFD_ASSERT_NOW(a_result_in_range, out_valid, (out_beat.humidity_centi <= HUM_MAX) && (out_beat.temperature_centi >= -15'sd4500))

endmodule

`default_nettype wire

@@ tb/cthfd_tb_pkg.sv @@
// Test-side helpers for the sensor frame decoder bench: CRC-8 arithmetic used
// both to build well-formed frames and to predict the decoder. No dependencies.
package cthfd_tb_pkg;

  localparam int FULL_SCALE = 65535;

  // Shifts one byte through the CRC-8 register (x^8+x^5+x^4+1), MSB first.
  function automatic logic [7:0] crc8_shift(logic [7:0] crc, logic [7:0] data);
    logic [8:0] r;
    r = {1'b0, crc ^ data};
    for (int i = 0; i < 8; i++) begin
      r = r << 1;
      if (r[8]) r = r ^ 9'h131;
    end
    return r[7:0];
  endfunction

  // CRC of a two-byte data word, starting from the all-ones preset.
  function automatic logic [7:0] word_crc(logic [15:0] word);
    return crc8_shift(crc8_shift(8'hFF, word[15:8]), word[7:0]);
  endfunction

endpackage

@@ tb/cthfd_frame_checker.sv @@
// Watches both channels of the frame decoder, predicts each result beat and
// compares it field by field. Depends on cthfd_pkg and cthfd_tb_pkg.
module cthfd_frame_checker
  import cthfd_pkg::*;
  import cthfd_tb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_beat_t  in_beat,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_beat_t out_beat,
  output int        mismatches,
  output int        results_owed
);

  logic [2:0]         next_slot;
  logic [7:0]         running_crc;
  logic [15:0]        word_acc;
  logic signed [14:0] temp_held;
  logic [13:0]        hum_held;
  logic               temp_ok;
  out_beat_t          readings_due[$];

  initial begin
    mismatches   = 0;
    results_owed = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Advances the decoder state by one accepted byte.
  task automatic decode_byte(input in_beat_t b);
    logic [2:0] slot;
    logic       match;
    out_beat_t  r;
    slot = b.frame_start ? POS_TEMP_HI : next_slot;
    if (slot >= FRAME_BYTES) slot = POS_TEMP_HI;
    match = (running_crc == b.data_byte);
    case (slot)
      POS_TEMP_HI, POS_HUM_HI: begin
        running_crc = crc8_shift(CRC_INIT, b.data_byte);
        word_acc    = {b.data_byte, 8'h00};
      end
      POS_TEMP_LO, POS_HUM_LO: begin
        running_crc   = crc8_shift(running_crc, b.data_byte);
        word_acc[7:0] = b.data_byte;
      end
      POS_TEMP_CRC: begin
        if (match)
          temp_held = 15'((int'(TEMP_SPAN) * int'(word_acc)) / FULL_SCALE
                          - int'(TEMP_OFFSET));
        temp_ok     = match;
        running_crc = CRC_INIT;
      end
      default: begin
        if (match) hum_held = 14'((int'(HUM_SPAN) * int'(word_acc)) / FULL_SCALE);
        running_crc           = CRC_INIT;
        r.temperature_centi   = temp_held;
        r.humidity_centi      = hum_held;
        r.temperature_crc_ok  = temp_ok;
        r.humidity_crc_ok     = match;
        readings_due.push_back(r);
      end
    endcase
    next_slot = (slot == POS_HUM_CRC) ? POS_TEMP_HI : slot + 3'd1;
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      next_slot   = POS_TEMP_HI;
      running_crc = CRC_INIT;
      word_acc    = '0;
      temp_held   = '0;
      hum_held    = '0;
      temp_ok     = 1'b0;
      readings_due.delete();
    end else begin
      // The result of a byte is registered and leaves in a later cycle, so outputs are checked first.
      if (out_valid && !out_stall) begin
        if (readings_due.size() == 0) begin
          report_mismatch("result beat with nothing pending", 1, 0);
        end else begin
          want = readings_due.pop_front();
          if (out_beat.temperature_centi !== want.temperature_centi)
            report_mismatch("temperature_centi", int'(out_beat.temperature_centi),
                            int'(want.temperature_centi));
          if (out_beat.humidity_centi !== want.humidity_centi)
            report_mismatch("humidity_centi", int'(out_beat.humidity_centi),
                            int'(want.humidity_centi));
          if (out_beat.temperature_crc_ok !== want.temperature_crc_ok)
            report_mismatch("temperature_crc_ok", int'(out_beat.temperature_crc_ok),
                            int'(want.temperature_crc_ok));
          if (out_beat.humidity_crc_ok !== want.humidity_crc_ok)
            report_mismatch("humidity_crc_ok", int'(out_beat.humidity_crc_ok),
                            int'(want.humidity_crc_ok));
        end
      end
      if (in_valid && !in_stall) decode_byte(in_beat);
    end
    results_owed <= readings_due.size();
  end

endmodule

@@ tb/tb_crc_checked_temp_humidity_frame_decoder.sv @@
// Top of the frame decoder bench: clock, reset, byte stimulus, output stalls
// and the verdict. Depends on cthfd_pkg, cthfd_tb_pkg and cthfd_frame_checker.
module tb_crc_checked_temp_humidity_frame_decoder;
  import cthfd_pkg::*;
  import cthfd_tb_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int LONG_HOLD  = 80;
  localparam int BYTE_GOAL  = 1100;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  int mismatches;
  int results_owed;
  int idle_cycles = 0;
  int bytes_sent = 0;
  int hold_requests = 0;
  int holds_served = 0;
  bit no_idle = 1'b0;

  crc_checked_temp_humidity_frame_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  cthfd_frame_checker frame_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_beat      (in_beat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_beat     (out_beat),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Ends the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("crc_checked_temp_humidity_frame_decoder test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: a random hold-off before each result beat (none while no_idle is set), or a long one on request.
  initial begin
    int wait_cycles;
    while (rst) @(posedge clk);
    forever begin
      if (hold_requests != holds_served) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        wait_cycles = no_idle ? 0 : $urandom_range(0, 4);
        if (wait_cycles != 0) begin
          out_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic logic [15:0] pick_word();
    logic [15:0] corners [6];
    corners = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF};
    if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 5)];
    return 16'($urandom);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fs);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{data_byte: b, frame_start: fs};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends the first n_bytes of a frame; a bad word gets a corrupted CRC byte.
  task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                            input bit t_good, input bit h_good, input bit mark,
                            input int n_bytes);
    logic [7:0] fb [6];
    fb[0] = t_raw[15:8];
    fb[1] = t_raw[7:0];
    fb[2] = word_crc(t_raw) ^ (t_good ? 8'h00 : 8'($urandom_range(1, 255)));
    fb[3] = h_raw[15:8];
    fb[4] = h_raw[7:0];
    fb[5] = word_crc(h_raw) ^ (h_good ? 8'h00 : 8'($urandom_range(1, 255)));
    for (int i = 0; i < n_bytes; i++) send_byte(fb[i], mark && (i == 0));
  endtask

  initial begin
    int frame_no;
    frame_no = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Scale extremes, a failed temperature word on an unmarked back-to-back
    // frame, and a restart after a partial frame that got past its first CRC.
    send_frame(16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1, 6);
    send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b1, 1'b0, 6);
    send_frame(16'hABCD, 16'h5555, 1'b1, 1'b1, 1'b1, 4);
    send_frame(16'h8000, 16'h7FFF, 1'b1, 1'b0, 1'b1, 6);

    while (bytes_sent < BYTE_GOAL) begin
      frame_no++;
      no_idle = (frame_no % 40) >= 30;
      if (frame_no == 60) hold_requests++;
      if (frame_no == 120) begin
        // Let the decoder drain completely before going on.
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
      end
      case ($urandom_range(0, 9))
        8: send_frame(pick_word(), pick_word(), 1'b1, 1'b1, $urandom_range(0, 1),
                      $urandom_range(1, 5));
        9: repeat ($urandom_range(1, 3))
             send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        default: send_frame(pick_word(), pick_word(), $urandom_range(0, 6) != 0,
                            $urandom_range(0, 6) != 0, $urandom_range(0, 3) != 0, 6);
      endcase
    end

    in_valid <= 1'b0;
    // The pending count is updated at the edge of the last byte, so read it
    // after the next edge.
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("crc_checked_temp_humidity_frame_decoder test passed");
    else
      $display("crc_checked_temp_humidity_frame_decoder test failed");
    $finish;
  end

endmodule
